FILE: rtl/otsu_pkg.sv
// Constants and types shared by the Otsu threshold search block.
package otsu_pkg;

	localparam int MAX_PIXELS = 1048576;
	localparam int LEVELS = 256;
	localparam int LVL_W = 8;

	localparam int CNT_W = $clog2(MAX_PIXELS + 1);
	localparam int SUM_W = CNT_W + LVL_W;
	localparam int PROD_W = SUM_W + CNT_W;
	localparam int P_W = 2 * CNT_W;
	localparam int SQ_W = 2 * PROD_W;
	localparam int WIDE_W = SQ_W + P_W;

	localparam int DIG_W = 4;
	localparam int MUL_DIGS = (PROD_W + DIG_W - 1) / DIG_W;
	localparam int MY_W = MUL_DIGS * DIG_W;
	localparam int ACC_W = SQ_W + MY_W;
	localparam int MCNT_W = $clog2(MUL_DIGS);

	localparam logic [LVL_W-1:0] FIRST_CAND = LVL_W'(1);
	localparam logic [LVL_W-1:0] LAST_CAND = LVL_W'(LEVELS - 2);
	localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);

	typedef logic [LVL_W-1:0] lvl_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [SUM_W-1:0] sum_t;

endpackage

FILE: rtl/otsu_threshold_search.sv
// Otsu threshold search: histogram memory, candidate sequencer and shared multiplier.
//
// Grey pixels stream in at one word per clock and are counted into a 256-bin histogram
// held in a synchronous memory, with forwarding for repeated levels. After the word
// marked last, the block reads the bins in order, clears each bin as it goes, and
// evaluates candidate thresholds 1 to 254 exactly in integers on one shared multiplier
// that retires four multiplier bits per cycle. A candidate with an empty class skips the
// multiplier. When the search is done the threshold word is offered and no pixel is
// taken until it is accepted. After reset the block clears the histogram before it
// takes the first pixel.
module otsu_threshold_search
	import otsu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LVL_W-1:0] pixel_level,
	input  logic             last_pixel,
	input  logic             in_valid,
	output logic             in_ready,
	output logic [LVL_W-1:0] threshold,
	output logic             out_valid,
	input  logic             out_ready
);

	typedef enum logic [3:0] {
		ST_CLR, ST_PIX, ST_DRAIN, ST_RD, ST_ACC, ST_CAND, ST_MUL,
		ST_DIFF, ST_DEC, ST_CMP, ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_A, OP_B, OP_P, OP_SQ, OP_L, OP_R
	} op_t;

	state_t state_q;
	op_t    op_q;

	cnt_t hist_mem [LEVELS];
	cnt_t rd_q;
	lvl_t rd_addr;
	logic mem_we;
	lvl_t mem_waddr;
	cnt_t mem_wdata;

	logic v_s1;
	lvl_t lvl_s1;
	logic lw_v_q;
	lvl_t lw_addr_q;
	cnt_t lw_data_q;
	cnt_t cnt_inc;

	cnt_t tot_n_q;
	sum_t tot_s_q;
	cnt_t n0_q;
	sum_t s0_q;
	cnt_t n1;
	sum_t s1;
	sum_t bin_sum;
	lvl_t j_q;

	logic [SQ_W-1:0]     mx_q;
	logic [MY_W-1:0]     my_q;
	logic [ACC_W-1:0]    macc_q;
	logic [MCNT_W-1:0]   mcnt_q;
	logic [SQ_W+DIG_W-1:0] pp;
	logic [ACC_W-1:0]    macc_nx;

	logic [PROD_W-1:0] a_q;
	logic [PROD_W-1:0] b_q;
	logic [PROD_W-1:0] d_q;
	logic [PROD_W-1:0] d_abs;
	logic [P_W-1:0]    p_q;
	logic [SQ_W-1:0]   dsq_q;
	logic [WIDE_W-1:0] lhs_q;
	logic [WIDE_W-1:0] rhs_q;
	logic [SQ_W-1:0]   best_sq_q;
	logic [P_W-1:0]    best_p_q;
	lvl_t              best_t_q;
	logic              out_valid_q;

	logic in_acc;

	assign in_ready  = (state_q == ST_PIX);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign threshold = best_t_q;

	assign rd_addr = (state_q == ST_PIX) ? pixel_level : j_q;

	assign cnt_inc = ((lw_v_q && (lw_addr_q == lvl_s1)) ? lw_data_q : rd_q) + CNT_W'(1);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = j_q;
		mem_wdata = '0;
		if (v_s1) begin
			mem_we    = 1'b1;
			mem_waddr = lvl_s1;
			mem_wdata = cnt_inc;
		end else if (state_q == ST_CLR || state_q == ST_ACC) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= hist_mem[rd_addr];
	end

	assign n1      = tot_n_q - n0_q;
	assign s1      = tot_s_q - s0_q;
	assign bin_sum = SUM_W'(j_q) * SUM_W'(rd_q);
	assign d_abs   = (a_q >= b_q) ? (a_q - b_q) : (b_q - a_q);

	assign pp      = (SQ_W + DIG_W)'(mx_q) * (SQ_W + DIG_W)'(my_q[MY_W-1 -: DIG_W]);
	assign macc_nx = {macc_q[ACC_W-DIG_W-1:0], DIG_W'(0)} + ACC_W'(pp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			op_q        <= OP_A;
			j_q         <= '0;
			v_s1        <= 1'b0;
			lvl_s1      <= '0;
			lw_v_q      <= 1'b0;
			lw_addr_q   <= '0;
			lw_data_q   <= '0;
			tot_n_q     <= '0;
			tot_s_q     <= '0;
			n0_q        <= '0;
			s0_q        <= '0;
			mx_q        <= '0;
			my_q        <= '0;
			macc_q      <= '0;
			mcnt_q      <= '0;
			a_q         <= '0;
			b_q         <= '0;
			d_q         <= '0;
			p_q         <= '0;
			dsq_q       <= '0;
			lhs_q       <= '0;
			rhs_q       <= '0;
			best_sq_q   <= '0;
			best_p_q    <= '0;
			best_t_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1      <= 1'b0;
			lw_v_q    <= v_s1;
			lw_addr_q <= lvl_s1;
			lw_data_q <= cnt_inc;
			case (state_q)
				ST_CLR: begin
					j_q <= j_q + LVL_W'(1);
					if (j_q == LAST_LVL) begin
						state_q <= ST_PIX;
					end
				end
				ST_PIX: begin
					if (in_acc) begin
						lvl_s1 <= pixel_level;
						if (tot_n_q < CNT_W'(MAX_PIXELS)) begin
							v_s1    <= 1'b1;
							tot_n_q <= tot_n_q + CNT_W'(1);
							tot_s_q <= tot_s_q + SUM_W'(pixel_level);
						end
						if (last_pixel) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					j_q       <= '0;
					n0_q      <= '0;
					s0_q      <= '0;
					best_sq_q <= '0;
					best_t_q  <= '0;
					state_q   <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					n0_q <= n0_q + rd_q;
					s0_q <= s0_q + bin_sum;
					if (j_q >= FIRST_CAND && j_q <= LAST_CAND) begin
						state_q <= ST_CAND;
					end else if (j_q == LAST_LVL) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end else begin
						j_q     <= j_q + LVL_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_CAND: begin
					if (n0_q == '0 || n1 == '0) begin
						d_q     <= '0;
						state_q <= ST_DEC;
					end else begin
						mx_q    <= SQ_W'(s0_q);
						my_q    <= MY_W'(n1);
						macc_q  <= '0;
						mcnt_q  <= MCNT_W'(MUL_DIGS - 1);
						op_q    <= OP_A;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					macc_q <= macc_nx;
					my_q   <= my_q << DIG_W;
					mcnt_q <= mcnt_q - MCNT_W'(1);
					if (mcnt_q == '0) begin
						macc_q <= '0;
						mcnt_q <= MCNT_W'(MUL_DIGS - 1);
						case (op_q)
							OP_A: begin
								a_q  <= macc_nx[PROD_W-1:0];
								mx_q <= SQ_W'(s1);
								my_q <= MY_W'(n0_q);
								op_q <= OP_B;
							end
							OP_B: begin
								b_q     <= macc_nx[PROD_W-1:0];
								state_q <= ST_DIFF;
							end
							OP_P: begin
								p_q  <= macc_nx[P_W-1:0];
								mx_q <= SQ_W'(d_q);
								my_q <= MY_W'(d_q);
								op_q <= OP_SQ;
							end
							OP_SQ: begin
								dsq_q <= macc_nx[SQ_W-1:0];
								if (best_sq_q == '0) begin
									best_sq_q <= macc_nx[SQ_W-1:0];
									best_p_q  <= p_q;
									best_t_q  <= j_q;
									j_q       <= j_q + LVL_W'(1);
									state_q   <= ST_RD;
								end else begin
									mx_q <= macc_nx[SQ_W-1:0];
									my_q <= MY_W'(best_p_q);
									op_q <= OP_L;
								end
							end
							OP_L: begin
								lhs_q <= macc_nx[WIDE_W-1:0];
								mx_q  <= best_sq_q;
								my_q  <= MY_W'(p_q);
								op_q  <= OP_R;
							end
							OP_R: begin
								rhs_q   <= macc_nx[WIDE_W-1:0];
								state_q <= ST_CMP;
							end
							default: begin
								state_q <= ST_DIFF;
							end
						endcase
					end
				end
				ST_DIFF: begin
					d_q     <= d_abs;
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (d_q == '0) begin
						if (best_sq_q == '0) begin
							best_t_q <= j_q;
						end
						j_q     <= j_q + LVL_W'(1);
						state_q <= ST_RD;
					end else begin
						mx_q    <= SQ_W'(n0_q);
						my_q    <= MY_W'(n1);
						macc_q  <= '0;
						mcnt_q  <= MCNT_W'(MUL_DIGS - 1);
						op_q    <= OP_P;
						state_q <= ST_MUL;
					end
				end
				ST_CMP: begin
					if (lhs_q >= rhs_q) begin
						best_sq_q <= dsq_q;
						best_p_q  <= p_q;
						best_t_q  <= j_q;
					end
					j_q     <= j_q + LVL_W'(1);
					state_q <= ST_RD;
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						tot_n_q     <= '0;
						tot_s_q     <= '0;
						state_q     <= ST_PIX;
					end
				end
				default: begin
					state_q <= ST_CLR;
				end
			endcase
		end
	end

endmodule

FILE: test/tb_otsu_threshold_search.sv
// Testbench for otsu_threshold_search: streams grey images and checks each threshold word.
`timescale 1ns / 100ps

module tb_otsu_threshold_search
	import otsu_pkg::*;
();

	localparam int CYCLE_LIMIT = 100_000_000;
	localparam int RANDOM_PIXELS = 1350;
	localparam int DIRECTED_PIXELS = 20;
	localparam int CALM_TAIL = 150;

	typedef enum int {
		SPREAD_BAND,
		SPREAD_PAIR,
		SPREAD_FULL
	} spread_t;

	typedef struct packed {
		lvl_t level;
		logic fin;
		logic steady;
		logic drain;
	} pixel_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	lvl_t pixel_level = '0;
	logic last_pixel = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	lvl_t threshold;
	logic out_valid;
	logic out_ready = 1'b0;

	pixel_word_t pending_pixels[$];
	lvl_t expected_thresholds[$];
	int unsigned hist_model[LEVELS];
	int unsigned hist_fill = 0;

	int total_pixels = 0;
	int pixels_taken = 0;
	int images_sent = 0;
	int thresholds_seen = 0;
	int errors = 0;
	int gap_left = 0;
	int stall_left = 0;
	int cycle_count = 0;
	logic calm = 1'b0;
	pixel_word_t next_word;
	lvl_t want;

	otsu_threshold_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_level(pixel_level),
		.last_pixel(last_pixel),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.threshold(threshold),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Exact between-class variance search; ties go to the later candidate.
	function automatic lvl_t otsu_level();
		logic [63:0] tot_n, tot_s, n0, s0, n1, s1, a, b, d, p, best_d, best_p;
		logic [191:0] lhs, rhs;
		lvl_t best_t;
		tot_n = '0;
		tot_s = '0;
		for (int j = 0; j < LEVELS; j++) begin
			tot_n += 64'(hist_model[j]);
			tot_s += 64'(j) * 64'(hist_model[j]);
		end
		n0 = 64'(hist_model[0]);
		s0 = '0;
		best_d = '0;
		best_p = 64'd1;
		best_t = '0;
		for (int j = int'(FIRST_CAND); j <= int'(LAST_CAND); j++) begin
			n0 += 64'(hist_model[j]);
			s0 += 64'(j) * 64'(hist_model[j]);
			n1 = tot_n - n0;
			s1 = tot_s - s0;
			if (n0 == '0 || n1 == '0) begin
				d = '0;
				p = 64'd1;
			end else begin
				a = s0 * n1;
				b = s1 * n0;
				d = (a >= b) ? a - b : b - a;
				p = n0 * n1;
			end
			lhs = 192'(d) * 192'(d) * 192'(best_p);
			rhs = 192'(best_d) * 192'(best_d) * 192'(p);
			if (lhs >= rhs) begin
				best_d = d;
				best_p = p;
				best_t = lvl_t'(j);
			end
		end
		return best_t;
	endfunction

	task automatic count_pixel(input lvl_t lvl, input logic fin);
		if (hist_fill < MAX_PIXELS) begin
			hist_model[lvl]++;
			hist_fill++;
		end
		if (fin) begin
			expected_thresholds.insert(expected_thresholds.size(), otsu_level());
			foreach (hist_model[k]) hist_model[k] = 0;
			hist_fill = 0;
		end
	endtask

	task automatic push_pixel(input int lvl, input logic fin, input logic steady,
			input logic drain);
		pixel_word_t w;
		w.level = lvl_t'(lvl);
		w.fin = fin;
		w.steady = steady;
		w.drain = drain;
		pending_pixels.insert(pending_pixels.size(), w);
		total_pixels++;
		if (fin)
			images_sent++;
	endtask

	task automatic add_image(input int size, input spread_t spread, input logic drain);
		int base, width, base2, width2, lvl;
		width = $urandom_range(1, 16);
		base = $urandom_range(0, 256 - width);
		width2 = $urandom_range(1, 8);
		base2 = $urandom_range(0, 256 - width2);
		for (int i = 0; i < size; i++) begin
			case (spread)
				SPREAD_BAND: lvl = base + $urandom_range(0, width - 1);
				SPREAD_PAIR: begin
					if ($urandom_range(1))
						lvl = base + $urandom_range(0, width - 1);
					else
						lvl = base2 + $urandom_range(0, width2 - 1);
				end
				default: lvl = $urandom_range(0, 255);
			endcase
			push_pixel(lvl, i == size - 1, 1'b0, drain && i == 0);
		end
	endtask

	// Sender: one word per handshake, with random gaps until the tail of the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				count_pixel(pixel_level, last_pixel);
				pixels_taken++;
			end
			calm <= pending_pixels.size() <= CALM_TAIL;
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_pixels.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pending_pixels[0].drain && expected_thresholds.size() != 0) begin
					in_valid <= 1'b0;
				end else begin
					next_word = pending_pixels.pop_front();
					in_valid <= 1'b1;
					pixel_level <= next_word.level;
					last_pixel <= next_word.fin;
					if (!next_word.steady && !calm && $urandom_range(11) == 0)
						gap_left = $urandom_range(1, 17);
				end
			end
		end
	end

	// Receiver: checks each threshold word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_thresholds.size() == 0) begin
					$error("threshold: no result expected, got %0d", threshold);
					errors++;
				end else begin
					want = expected_thresholds.pop_front();
					thresholds_seen++;
					if (threshold !== want) begin
						$error("threshold: expected %0d, got %0d", want, threshold);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(9) == 0) begin
				stall_left = $urandom_range(0, 16);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles.", cycle_count);
			$display("otsu_threshold_search: mismatch");
			$finish;
		end
	end

	initial begin
		int size, pick;
		spread_t spread;
		foreach (hist_model[k]) hist_model[k] = 0;

		// Single-pixel images at the extremes and a uniform image give 254; the other directed images mix two to four levels.
		push_pixel(0, 1'b1, 1'b0, 1'b0);
		push_pixel(255, 1'b1, 1'b0, 1'b1);
		push_pixel(0, 1'b0, 1'b0, 1'b0);
		push_pixel(255, 1'b1, 1'b0, 1'b0);
		push_pixel(128, 1'b0, 1'b0, 1'b0);
		push_pixel(128, 1'b0, 1'b0, 1'b0);
		push_pixel(128, 1'b1, 1'b0, 1'b0);
		push_pixel(10, 1'b0, 1'b0, 1'b0);
		push_pixel(10, 1'b0, 1'b0, 1'b0);
		push_pixel(200, 1'b1, 1'b0, 1'b0);
		push_pixel(0, 1'b0, 1'b0, 1'b0);
		push_pixel(1, 1'b0, 1'b0, 1'b0);
		push_pixel(1, 1'b1, 1'b0, 1'b0);
		push_pixel(254, 1'b0, 1'b0, 1'b0);
		push_pixel(255, 1'b0, 1'b0, 1'b0);
		push_pixel(255, 1'b1, 1'b0, 1'b0);
		push_pixel(8'h55, 1'b0, 1'b0, 1'b0);
		push_pixel(8'hAA, 1'b0, 1'b0, 1'b0);
		push_pixel(8'h0F, 1'b0, 1'b0, 1'b0);
		push_pixel(8'hF0, 1'b1, 1'b0, 1'b0);

		// Random images: mostly small, mostly narrow level bands that search quickly.
		while (total_pixels < DIRECTED_PIXELS + RANDOM_PIXELS) begin
			size = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
			pick = $urandom_range(9);
			spread = (pick < 6) ? SPREAD_BAND : ((pick < 8) ? SPREAD_PAIR : SPREAD_FULL);
			add_image(size, spread, $urandom_range(9) == 0);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pixels_taken < total_pixels || expected_thresholds.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		$display("Sent %0d images in %0d pixels: single-pixel, uniform and random band images.",
			images_sent, total_pixels);
		$display("Checked %0d thresholds in %0d cycles.", thresholds_seen, cycle_count);
		if (errors == 0)
			$display("otsu_threshold_search: match");
		else
			$display("otsu_threshold_search: mismatch");
		$finish;
	end

endmodule
